FILE: sv/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes of the sorted priority queue
// Beat layouts, the stored entry, operation and status codes, and the
// control bundle that the sequencer broadcasts to every cell.
// ----------------------------------------------------------------------------
package spq_pkg;

	// Operation codes carried in the input beat.
	localparam logic [2:0] OP_ENQUEUE = 3'd0;
	localparam logic [2:0] OP_PREPEND = 3'd1;
	localparam logic [2:0] OP_DEQUEUE = 3'd2;
	localparam logic [2:0] OP_FIND    = 3'd3;
	localparam logic [2:0] OP_REMOVE  = 3'd4;

	// Status codes carried in the output beat.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	// One stored queue entry.
	typedef struct packed {
		logic [15:0] prio;
		logic [7:0]  row;
		logic [7:0]  col;
		logic [15:0] tag;
	} entry_t;

	// Input beat.
	typedef struct packed {
		logic [2:0]  operation;
		logic [15:0] priority_req;
		logic [7:0]  grid_row;
		logic [7:0]  grid_col;
		logic [15:0] element_tag;
	} in_beat_t;

	// Output beat.
	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] out_tag;
		logic [15:0] out_priority;
		logic [7:0]  out_row;
		logic [7:0]  out_col;
		logic [6:0]  entry_count;
		logic        head_valid;
		logic [15:0] head_tag;
	} out_beat_t;

	// Control broadcast from the sequencer to the cells.
	typedef struct packed {
		logic       cmp_en;
		logic       ins_en;
		logic       rem_en;
		logic [2:0] op;
	} cell_ctl_t;

endpackage

FILE: sv/spq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell: one slot of the queue chain
// Holds one entry, registers its own hit during the compare cycle, and on the
// apply cycle takes the new entry or shifts from its left or right neighbor.
// ----------------------------------------------------------------------------
module spq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  spq_pkg::cell_ctl_t ctl,
	input  spq_pkg::entry_t    key,
	input  logic               is_head,
	input  spq_pkg::entry_t    left_entry,
	input  logic               left_valid,
	input  spq_pkg::entry_t    right_entry,
	input  logic               right_valid,
	input  logic               before_in,
	output logic               before_out,
	input  spq_pkg::entry_t    sel_in,
	output spq_pkg::entry_t    sel_out,
	output spq_pkg::entry_t    entry,
	output logic               valid
);

	spq_pkg::entry_t entry_q;
	logic            valid_q;
	logic            hit_q;
	logic            hit;
	logic            first;
	logic            at_or_after;

	// Local hit test for the operation held by the sequencer.
	always_comb begin
		case (ctl.op)
			spq_pkg::OP_ENQUEUE: hit = !valid_q || (entry_q.prio > key.prio);
			spq_pkg::OP_PREPEND: hit = is_head;
			spq_pkg::OP_DEQUEUE: hit = is_head && valid_q;
			spq_pkg::OP_FIND,
			spq_pkg::OP_REMOVE:  hit = valid_q && (entry_q.row == key.row)
			                          && (entry_q.col == key.col);
			default:             hit = 1'b0;
		endcase
	end

	// Hit flag, captured in the compare cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.cmp_en) begin
			hit_q <= hit;
		end
	end

	// This cell is the first hit when no cell in front of it hit.
	assign first       = hit_q && !before_in;
	assign at_or_after = hit_q || before_in;
	assign before_out  = at_or_after;
	assign sel_out     = sel_in | (first ? entry_q : '0);

	// Valid flag: cells at or behind the change point move with their neighbor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.ins_en && at_or_after) begin
			valid_q <= first ? 1'b1 : left_valid;
		end else if (ctl.rem_en && at_or_after) begin
			valid_q <= right_valid;
		end
	end

	// Entry payload follows the same shift as the valid flag.
	always_ff @(posedge clk) begin
		if (ctl.ins_en && at_or_after) begin
			entry_q <= first ? key : left_entry;
		end else if (ctl.rem_en && at_or_after) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;
	assign valid = valid_q;

endmodule

FILE: sv/sorted_priority_queue_with_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_with_lookup: ordered entry store with position search
// A row of CAPACITY cells kept in order from front to back, with a small
// sequencer that runs enqueue, prepend, dequeue, find and remove on it.
// ----------------------------------------------------------------------------
// Each accepted beat runs through these steps before the next is taken: the
// accept cycle, a compare cycle in which every cell tests itself against the
// request in parallel, an apply cycle in which the first hit is resolved along
// the cell chain and the row shifts one place on an insert or removal, and a
// report cycle that loads the output register (held longer while the output
// is stalled). The clock period is set by the first-hit chain through all
// CAPACITY cells in the apply cycle. The store needs no clearing after reset.
// ----------------------------------------------------------------------------
module sorted_priority_queue_with_lookup #(
	parameter int CAPACITY = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  spq_pkg::in_beat_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output spq_pkg::out_beat_t  out_data
);

	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_CMP    = 4'b0010,
		S_APPLY  = 4'b0100,
		S_REPORT = 4'b1000
	} state_t;

	state_t             state_q;
	logic [2:0]         op_q;
	spq_pkg::entry_t    key_q;
	logic [CW-1:0]      count_q;
	logic               full;
	logic               is_insert;
	logic               is_take;
	logic               any_hit;
	spq_pkg::cell_ctl_t ctl;
	logic [1:0]         res_status_q;
	spq_pkg::entry_t    res_entry_q;
	logic               out_valid_q;
	spq_pkg::out_beat_t out_q;
	logic [CW+6:0]      count_ext;

	spq_pkg::entry_t    ent_pad [CAPACITY+2];
	logic [CAPACITY+1:0] vld_pad;
	logic [CAPACITY:0]  before_chain;
	spq_pkg::entry_t    sel_chain [CAPACITY+1];

	assign in_ready = (state_q == S_IDLE);

	// Operation decode.
	assign full      = (count_q == CW'(CAPACITY));
	assign is_insert = (op_q == spq_pkg::OP_ENQUEUE) || (op_q == spq_pkg::OP_PREPEND);
	assign is_take   = (op_q == spq_pkg::OP_DEQUEUE) || (op_q == spq_pkg::OP_FIND)
	                   || (op_q == spq_pkg::OP_REMOVE);
	assign any_hit   = before_chain[CAPACITY];

	// Control broadcast to the cell row.
	always_comb begin
		ctl.cmp_en = (state_q == S_CMP);
		ctl.ins_en = (state_q == S_APPLY) && is_insert && !full;
		ctl.rem_en = (state_q == S_APPLY)
		             && ((op_q == spq_pkg::OP_DEQUEUE) || (op_q == spq_pkg::OP_REMOVE));
		ctl.op     = op_q;
	end

	// Chain ends: nothing lies in front of the head or behind the tail.
	assign ent_pad[0]             = '0;
	assign ent_pad[CAPACITY+1]    = '0;
	assign vld_pad[0]             = 1'b0;
	assign vld_pad[CAPACITY+1]    = 1'b0;
	assign before_chain[0]        = 1'b0;
	assign sel_chain[0]           = '0;

	// Cell row.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		spq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.key         (key_q),
			.is_head     (i == 0),
			.left_entry  (ent_pad[i]),
			.left_valid  (vld_pad[i]),
			.right_entry (ent_pad[i+2]),
			.right_valid (vld_pad[i+2]),
			.before_in   (before_chain[i]),
			.before_out  (before_chain[i+1]),
			.sel_in      (sel_chain[i]),
			.sel_out     (sel_chain[i+1]),
			.entry       (ent_pad[i+1]),
			.valid       (vld_pad[i+1])
		);
	end

	// Sequencer and entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					state_q <= S_REPORT;
					if (ctl.ins_en) begin
						count_q <= count_q + CW'(1);
					end else if (ctl.rem_en && any_hit) begin
						count_q <= count_q - CW'(1);
					end
				end
				S_REPORT: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request capture on the accepted beat.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q       <= in_data.operation;
			key_q.prio <= in_data.priority_req;
			key_q.row  <= in_data.grid_row;
			key_q.col  <= in_data.grid_col;
			key_q.tag  <= in_data.element_tag;
		end
	end

	// Result capture in the apply cycle, from the pre-update contents.
	always_ff @(posedge clk) begin
		if (state_q == S_APPLY) begin
			if (is_insert) begin
				res_status_q <= full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
			end else if (is_take && any_hit) begin
				res_status_q <= spq_pkg::ST_OK;
			end else begin
				res_status_q <= spq_pkg::ST_NOTFOUND;
			end
			res_entry_q <= (is_take && any_hit) ? sel_chain[CAPACITY] : '0;
		end
	end

	assign count_ext = (CW + 7)'(count_q);

	// Output register: loaded in the report cycle once the previous beat left.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_REPORT) && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_REPORT) && (!out_valid_q || out_ready)) begin
			out_q.status       <= res_status_q;
			out_q.out_tag      <= res_entry_q.tag;
			out_q.out_priority <= res_entry_q.prio;
			out_q.out_row      <= res_entry_q.row;
			out_q.out_col      <= res_entry_q.col;
			out_q.entry_count  <= count_ext[6:0];
			out_q.head_valid   <= vld_pad[1];
			out_q.head_tag     <= vld_pad[1] ? ent_pad[1].tag : 16'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: sv/spq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker: port-level checks of the sorted priority queue
// Watches the output channel and checks the consistency of each result beat.
// ----------------------------------------------------------------------------
module spq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input spq_pkg::out_beat_t out_data
);

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	// A nonzero count always comes with a valid head.
	a_head_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.entry_count != 7'd0) |-> out_data.head_valid)
		else $error("count nonzero but head not valid");

	// An empty store reports a zero count and a zero head tag.
	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.head_valid
		|-> (out_data.head_tag == 16'd0) && (out_data.entry_count == 7'd0))
		else $error("empty store reports a head or a count");

	// A failed operation returns no entry.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status != spq_pkg::ST_OK)
		|-> (out_data.out_tag == 16'd0) && (out_data.out_priority == 16'd0)
		    && (out_data.out_row == 8'd0) && (out_data.out_col == 8'd0))
		else $error("failed operation returned an entry");

	// A full store is never empty.
	a_full_head: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == spq_pkg::ST_FULL) |-> out_data.head_valid)
		else $error("full status with an empty store");

endmodule

bind sorted_priority_queue_with_lookup spq_checker u_spq_checker (.*);
